### hw/rtl/mbtcp_pkg.sv
// ----------------------------------------------------------------------------
// Modbus TCP register server package
// Shared constants for the register server.
// ----------------------------------------------------------------------------
package mbtcp_pkg;

   localparam logic [7:0] FN_READ_COILS    = 8'd1;
   localparam logic [7:0] FN_READ_DISCRETE = 8'd2;
   localparam logic [7:0] FN_READ_HOLDING  = 8'd3;
   localparam logic [7:0] FN_READ_INPUT    = 8'd4;
   localparam logic [7:0] FN_WRITE_SINGLE  = 8'd6;
   localparam logic [7:0] FN_WRITE_COILS   = 8'd15;
   localparam logic [7:0] FN_WRITE_MULTI   = 8'd16;

   localparam logic [15:0] TABLE_INIT0 = 16'hABCD;
   localparam logic [15:0] TABLE_INIT1 = 16'hDEAD;

   localparam logic [7:0] LIMIT_RESET = 8'd100;

   typedef enum logic {
      KIND_PUSH = 1'b0,
      KIND_PULL = 1'b1
   } kind_type;

endpackage

### hw/rtl/modbus_tcp_register_server.sv
// ----------------------------------------------------------------------------
// Modbus TCP register server
// Byte-wide Modbus TCP server with a holding register table.
// ----------------------------------------------------------------------------
// Usage: each req beat is a push (req_kind 0, one request byte in req_rx_byte)
// or a pull (req_kind 1). Pushes give no rsp beat; each pull gives exactly one
// rsp beat carrying the next reply byte, rsp_tx_last on the final byte, or
// rsp_tx_empty with a zero byte when no reply is pending.
// Pushes arriving while a reply is pending are dropped.
// Throughput: one req beat per cycle while req_ready is high. A pull's rsp
// beat is registered, appearing in the cycle after acceptance; the table
// read for a reply word is a registered memory read fetched while the byte
// before it goes out; the frame buffer read likewise uses a registered port.
// The rsp output register holds one beat; req_ready drops while that
// register is full and not being taken, and during the reset table sweep,
// so a stalled receiver blocks pulls and pushes alike.
// Reset: control state clears synchronously; the register table is then swept
// back to its reset contents, one entry per cycle, during which req_ready is
// low. csr writes are taken whenever reset is low, also during the sweep.
// ----------------------------------------------------------------------------
module modbus_tcp_register_server #(
   parameter int TABLE_DEPTH = 128,
   parameter int FRAME_BYTES = 260
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_tx_last,
   output logic       rsp_tx_empty,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = AW + 1;

   // Frame buffer: only bytes 0..13 (header, addr, qty, byte count and first
   // code 16 data byte) are held in flops; later data is streamed.
   logic [7:0] hdr_ff [0:13];
   logic [7:0] hdr_in [0:13];

   logic [15:0] tbl [0:TABLE_DEPTH-1];

   logic [8:0]  rpos_ff, rpos_in;
   logic [8:0]  spos_ff, spos_in;
   logic        pend_ff, pend_in;
   logic [7:0]  limit_ff;
   logic [7:0]  prev_ff, prev_in;   // previous pushed byte for code 16 words
   logic [CW-1:0] clr_ff;
   logic        clr_busy;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff, rsp_empty_ff;

   // Echo store for frames longer than the header flops.
   logic [7:0]  echo_mem [0:FRAME_BYTES-1];
   logic [7:0]  echo_rd_ff;
   logic [15:0] tbl_rd_ff;

   logic        accept, push, pull;
   assign clr_busy  = (clr_ff != CW'(TABLE_DEPTH));
   assign req_ready = !clr_busy && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign push      = accept && (req_kind == mbtcp_pkg::KIND_PUSH);
   assign pull      = accept && (req_kind == mbtcp_pkg::KIND_PULL);

   // ---------------- decode of the stored request ----------------
   logic [15:0] len_raw;
   logic [8:0]  fend;
   assign len_raw = {hdr_ff[4], hdr_ff[5]};
   assign fend = (len_raw > 16'(FRAME_BYTES - 6)) ? 9'(FRAME_BYTES)
                                                  : 9'(len_raw + 16'd6);

   function automatic logic [7:0] hb(input logic [7:0] v, input int i,
                                     input logic [8:0] fe);
      return (9'(i) < fe) ? v : 8'd0;
   endfunction

   logic [7:0]  fn;
   logic [15:0] addr, qty;
   assign fn   = hb(hdr_ff[7], 7, fend);
   assign addr = {hb(hdr_ff[8], 8, fend), hb(hdr_ff[9], 9, fend)};
   assign qty  = {hb(hdr_ff[10], 10, fend), hb(hdr_ff[11], 11, fend)};

   logic is_coil, is_reg, is_wr;
   assign is_coil = (fn == mbtcp_pkg::FN_READ_COILS) ||
                    (fn == mbtcp_pkg::FN_READ_DISCRETE);
   assign is_reg  = (fn == mbtcp_pkg::FN_READ_HOLDING) ||
                    (fn == mbtcp_pkg::FN_READ_INPUT);
   assign is_wr   = (fn == mbtcp_pkg::FN_WRITE_COILS) ||
                    (fn == mbtcp_pkg::FN_WRITE_MULTI);

   logic [10:0] qcoil;
   logic [7:0]  coil_bytes;
   logic [6:0]  nreg;
   logic [8:0]  total;
   assign qcoil      = (qty > 16'd2000) ? 11'd2000 : qty[10:0];
   assign coil_bytes = 8'((qcoil + 11'd7) >> 3);
   assign nreg       = (qty > 16'd125) ? 7'd125 : qty[6:0];
   always_comb begin
      if (is_coil)     total = 9'd9 + 9'(coil_bytes);
      else if (is_reg) total = 9'd9 + {1'b0, nreg, 1'b0};
      else if (is_wr)  total = 9'd12;
      else             total = fend;
   end

   function automatic logic addr_ok(input logic [16:0] a, input logic [7:0] lim);
      return (a < 17'(lim)) && (a < 17'(TABLE_DEPTH));
   endfunction

   // ---------------- push path ----------------
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0] wr_data;
   logic [8:0]  new_fend;
   logic [15:0] p_len;
   logic [16:0] wa;
   logic [8:0]  widx;

   always_comb begin
      for (int i = 0; i < 14; i++) hdr_in[i] = hdr_ff[i];
      rpos_in = rpos_ff;
      pend_in = pend_ff;
      prev_in = prev_ff;
      wr_en   = 1'b0;
      wr_data = 16'd0;
      wa      = 17'd0;
      widx    = 9'd0;
      p_len   = 16'd0;
      new_fend = fend;
      if (push && !pend_ff && (rpos_ff < 9'(FRAME_BYTES))) begin
         for (int i = 0; i < 14; i++)
            if (rpos_ff == 9'(i)) hdr_in[i] = req_rx_byte;
         prev_in = req_rx_byte;
         // frame end as it stands once this byte is stored
         p_len = (rpos_ff == 9'd5) ? {hdr_ff[4], req_rx_byte} : len_raw;
         new_fend = (p_len > 16'(FRAME_BYTES - 6)) ? 9'(FRAME_BYTES)
                                                   : 9'(p_len + 16'd6);
         if (rpos_ff >= 9'd5) begin
            if (fn == mbtcp_pkg::FN_WRITE_SINGLE && rpos_ff == 9'd11) begin
               wa = {1'b0, addr};
               wr_data = {hdr_ff[10], req_rx_byte};
               wr_en = addr_ok(wa, limit_ff);
            end else if (fn == mbtcp_pkg::FN_WRITE_MULTI && rpos_ff >= 9'd14 &&
                         rpos_ff[0] == 1'b0) begin
               widx = (rpos_ff - 9'd14) >> 1;
               wa = 17'(addr) + 17'(widx);
               wr_data = {prev_ff, req_rx_byte};
               wr_en = (16'(widx) < qty) && addr_ok(wa, limit_ff);
            end
            if (rpos_ff + 9'd1 >= new_fend) begin
               pend_in = 1'b1;
               rpos_in = 9'd0;
            end else begin
               rpos_in = rpos_ff + 9'd1;
            end
         end else begin
            rpos_in = rpos_ff + 9'd1;
         end
      end
      wr_addr = wa[AW-1:0];
   end

   // ---------------- pull path ----------------
   // Registered reads are prefetched for the next send position.
   logic [8:0]  j;
   logic [7:0]  tx_byte;
   logic        tx_last;
   logic [8:0]  k;
   logic [16:0] ra;
   logic [8:0]  nxt;
   logic [16:0] ra_next;
   logic        ok_cur;

   assign j = spos_ff;
   assign k = j - 9'd9;
   assign ra = 17'(addr) + 17'(k >> 1);
   assign ok_cur = addr_ok(ra, limit_ff);

   always_comb begin
      spos_in = spos_ff;
      tx_byte = 8'd0;
      tx_last = 1'b0;
      if (j == 9'd4)      tx_byte = 8'(9'(total - 9'd6) >> 8);
      else if (j == 9'd5) tx_byte = 8'(total - 9'd6);
      else if (j < 9'd14) tx_byte = (j < fend) ? hdr_ff[j[3:0]] : 8'd0;
      else                tx_byte = (j < fend) ? echo_rd_ff : 8'd0;
      if (j >= 9'd8) begin
         if (is_coil) tx_byte = (j == 9'd8) ? coil_bytes : 8'd0;
         else if (is_reg) begin
            if (j == 9'd8) tx_byte = {nreg, 1'b0};
            else if (!ok_cur) tx_byte = 8'd0;
            else tx_byte = k[0] ? tbl_rd_ff[7:0] : tbl_rd_ff[15:8];
         end
      end
      if (pull && pend_ff) begin
         if (j + 9'd1 >= total) begin
            tx_last = 1'b1;
            spos_in = 9'd0;
         end else begin
            spos_in = j + 9'd1;
         end
      end
   end

   // Address for the next registered reads.
   assign nxt = (pull && pend_ff) ? spos_in : spos_ff;
   assign ra_next = 17'(addr) + 17'(9'(nxt - 9'd9) >> 1);

   always_ff @(posedge clock) begin
      if (clr_busy) begin
         tbl[clr_ff[AW-1:0]] <= (clr_ff == CW'(0)) ? mbtcp_pkg::TABLE_INIT0 :
                                (clr_ff == CW'(1)) ? mbtcp_pkg::TABLE_INIT1 : 16'd0;
      end else if (wr_en) begin
         tbl[wr_addr] <= wr_data;
      end
      tbl_rd_ff <= tbl[ra_next[AW-1:0]];
      if (push && !pend_ff && (rpos_ff < 9'(FRAME_BYTES)))
         echo_mem[rpos_ff] <= req_rx_byte;
      echo_rd_ff <= echo_mem[(nxt < 9'(FRAME_BYTES)) ? nxt : 9'd0];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 14; i++) hdr_ff[i] <= hdr_in[i];
      prev_ff <= prev_in;
      if (reset) begin
         rpos_ff      <= 9'd0;
         spos_ff      <= 9'd0;
         pend_ff      <= 1'b0;
         limit_ff     <= mbtcp_pkg::LIMIT_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rpos_ff <= rpos_in;
         spos_ff <= spos_in;
         pend_ff <= (pull && pend_ff && tx_last) ? 1'b0 : pend_in;
         if (csr_we) limit_ff <= csr_wdata;
         if (clr_busy) clr_ff <= clr_ff + CW'(1);
         if (pull) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      if (pull) begin
         rsp_byte_ff  <= pend_ff ? tx_byte : 8'd0;
         rsp_last_ff  <= pend_ff ? tx_last : 1'b0;
         rsp_empty_ff <= !pend_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tx_byte  = rsp_byte_ff;
   assign rsp_tx_last  = rsp_last_ff;
   assign rsp_tx_empty = rsp_empty_ff;

endmodule
